>>> rtl/xfau_pkg.sv
// Package for the extended float arithmetic unit: item types, codes and helpers.
// Used by every module of the block; depends on nothing.
package xfau_pkg;

  localparam int unsigned SigW = 64;
  localparam int unsigned ExpW = 15;
  localparam int unsigned QueueDepth = 2;
  localparam logic [ExpW-1:0] ExpMax = 15'h7FFF;
  localparam logic [ExpW-1:0] ExpBias = 15'd16383;
  localparam logic [SigW-1:0] SigTop = 64'h8000_0000_0000_0000;
  localparam logic [SigW-1:0] SigNan = 64'h8000_0000_0000_0001;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_EQ = 3'd4, OP_GT = 3'd5, OP_LT = 3'd6, OP_NONE = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ERR_OK = 3'd0, ERR_INF_INF = 3'd1, ERR_ZERO_ZERO = 3'd2,
    ERR_DIV_ZERO = 3'd3, ERR_OVERFLOW = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_NORM, ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]      req_type;
    logic            a_sign;
    logic [ExpW-1:0] a_exponent;
    logic [SigW-1:0] a_significand;
    logic            b_sign;
    logic [ExpW-1:0] b_exponent;
    logic [SigW-1:0] b_significand;
  } in_item_t;

  typedef struct packed {
    logic            res_sign;
    logic [ExpW-1:0] res_exponent;
    logic [SigW-1:0] res_significand;
    logic            compare_true;
    logic [2:0]      error_code;
  } out_item_t;

  // Classified item handed from front to back.
  typedef struct packed {
    op_t             op;
    logic            a_sign;
    logic [ExpW-1:0] a_exp;
    logic [SigW-1:0] a_sig;
    logic            b_sign;
    logic [ExpW-1:0] b_exp;
    logic [SigW-1:0] b_sig;
    logic            a_zero;
    logic            b_zero;
    logic            a_nan;
    logic            b_nan;
    logic            a_inf;
    logic            b_inf;
  } task_t;

  function automatic logic is_nan(input logic [ExpW-1:0] e, input logic [SigW-1:0] m);
    is_nan = (e == ExpMax) && (m[63] && (m[62] || (m[61:0] != '0)));
  endfunction

  function automatic logic is_inf(input logic [ExpW-1:0] e, input logic [SigW-1:0] m);
    is_inf = (e == ExpMax) && (m[63:62] == 2'b10) && (m[61:0] == '0);
  endfunction

endpackage

>>> rtl/xfau_front.sv
// Front end: accepts input beats, classifies operands and fills the task queue.
// Depends on xfau_pkg.
module xfau_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  xfau_pkg::in_item_t in_data,
  output logic              tq_valid,
  input  logic              tq_take,
  output xfau_pkg::task_t   tq_data
);
  import xfau_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  task_t           mem_r [QueueDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;
  task_t           cls;
  logic            push, pop;

  always_comb begin
    cls.op     = op_t'(in_data.req_type);
    cls.a_sign = in_data.a_sign;
    cls.a_exp  = in_data.a_exponent;
    cls.a_sig  = in_data.a_significand;
    cls.b_sign = in_data.b_sign;
    cls.b_exp  = in_data.b_exponent;
    cls.b_sig  = in_data.b_significand;
    cls.a_zero = (in_data.a_exponent == '0) && (in_data.a_significand == '0);
    cls.b_zero = (in_data.b_exponent == '0) && (in_data.b_significand == '0);
    cls.a_nan  = is_nan(in_data.a_exponent, in_data.a_significand);
    cls.b_nan  = is_nan(in_data.b_exponent, in_data.b_significand);
    cls.a_inf  = is_inf(in_data.a_exponent, in_data.a_significand);
    cls.b_inf  = is_inf(in_data.b_exponent, in_data.b_significand);
  end

  assign in_stall = (cnt_r == (PtrW+1)'(QueueDepth));
  assign push     = in_valid && !in_stall;
  assign tq_valid = (cnt_r != '0);
  assign pop      = tq_valid && tq_take;
  assign tq_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PtrW+1)'(QueueDepth)) else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1)) else $error("count lost a push");

endmodule

>>> rtl/xfau_back.sv
// Back end: executes one task at a time (add/sub/compare direct, mul over four
// 32x32 passes, divide bit-serial), normalizes and holds the result. Depends on xfau_pkg.
module xfau_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tq_valid,
  output logic                tq_take,
  input  xfau_pkg::task_t     tq_data,
  output logic                out_valid,
  input  logic                out_stall,
  output xfau_pkg::out_item_t out_data
);
  import xfau_pkg::*;

  state_t          st_r, st_nxt;
  logic            sign_r;
  logic [16:0]     exp_r;
  logic [SigW-1:0] sig_r;
  logic            cmp_r;
  err_t            err_r;
  logic [SigW-1:0] rem_r, lo_r, y_r, mb_r;
  logic [127:0]    prod_r;
  logic [6:0]      cnt_r;
  logic [SigW-1:0] ma_r;

  task_t t;
  assign t = tq_data;

  // Add/sub path
  logic            as_sub, as_sign, as_swap;
  logic [ExpW-1:0] xe, ye;
  logic [SigW-1:0] xm, ym, s1, s2;
  logic [16:0]     d;
  logic [ExpW-1:0] big_e;
  logic [SigW:0]   sum;
  logic [SigW-1:0] dif;
  logic            gt_r1, lt_r1, eq_r1;

  always_comb begin
    logic xs, ys, sub_b;
    xs = t.a_sign;
    sub_b = (t.op == OP_SUB) ? !t.b_sign : t.b_sign;
    ys = sub_b;
    as_sub = (xs != ys);
    // magnitude subtract orientation: positive first
    as_swap = as_sub && xs;
    xe = as_swap ? t.b_exp : t.a_exp;
    xm = as_swap ? t.b_sig : t.a_sig;
    ye = as_swap ? t.a_exp : t.b_exp;
    ym = as_swap ? t.a_sig : t.b_sig;
    d = {2'b0, xe} - {2'b0, ye};
    s1 = xm;
    s2 = ym;
    if (!d[16]) begin
      s2 = (d >= 17'd64) ? '0 : (ym >> d[5:0]);
      big_e = xe;
    end else begin
      s1 = ((-d) >= 17'd64) ? '0 : (xm >> (6'(-d)));
      big_e = ye;
    end
    sum = {1'b0, s1} + {1'b0, s2};
    dif = (s1 > s2) ? s1 - s2 : s2 - s1;
    as_sign = as_sub ? (s1 < s2) : xs;
  end

  // Compares
  always_comb begin
    logic an;
    an = t.a_nan || t.b_nan;
    eq_r1 = !an && ((t.a_zero && t.b_zero) ||
            (t.a_sign == t.b_sign && t.a_exp == t.b_exp && t.a_sig == t.b_sig));
    if (an) gt_r1 = 1'b0;
    else if (t.a_inf) gt_r1 = !t.a_sign;
    else if (!t.a_sign) gt_r1 = t.b_sign ? 1'b1 :
      (t.a_exp != t.b_exp) ? (t.a_exp > t.b_exp) : (t.a_sig > t.b_sig);
    else gt_r1 = !t.b_sign ? 1'b0 :
      (t.a_exp != t.b_exp) ? (t.a_exp < t.b_exp) : (t.a_sig < t.b_sig);
    if (an) lt_r1 = 1'b0;
    else if (t.a_inf) lt_r1 = t.a_sign;
    else if (!t.a_sign) lt_r1 = t.b_sign ? 1'b0 :
      (t.a_exp != t.b_exp) ? (t.a_exp < t.b_exp) : (t.a_sig < t.b_sig);
    else lt_r1 = !t.b_sign ? 1'b1 :
      (t.a_exp != t.b_exp) ? (t.a_exp > t.b_exp) : (t.a_sig > t.b_sig);
  end

  // Divide step
  logic [SigW:0]   dv_sh;
  logic            dv_ge;
  assign dv_sh = {rem_r, lo_r[63]};
  assign dv_ge = dv_sh >= {1'b0, y_r};

  // Multiply partial product: one 32x32 pass per cycle
  logic [1:0]   mk;
  logic [31:0]  ma_part, mb_part;
  logic [63:0]  pp;
  logic [127:0] pp_sh, prod_sum;
  assign mk       = 2'(7'd4 - cnt_r);
  assign ma_part  = mk[0] ? ma_r[63:32] : ma_r[31:0];
  assign mb_part  = mk[1] ? mb_r[63:32] : mb_r[31:0];
  assign pp       = ma_part * mb_part;
  assign prod_sum = prod_r + pp_sh;

  always_comb begin
    case (mk)
      2'd0:    pp_sh = {64'b0, pp};
      2'd1,
      2'd2:    pp_sh = {32'b0, pp, 32'b0};
      default: pp_sh = {pp, 64'b0};
    endcase
  end

  logic [SigW-1:0] hi0;
  assign hi0 = t.a_sig >> 1;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (tq_valid) begin
        case (t.op)
          OP_MUL:  st_nxt = (t.a_zero || t.b_zero) ? ST_DONE : ST_MUL;
          OP_DIV:  st_nxt = (t.a_nan || t.b_nan || t.a_inf || t.a_zero || t.b_zero ||
                             t.b_sig == '0 || (hi0 >= t.b_sig && (hi0 >> 1) >= t.b_sig))
                            ? ST_DONE : ST_DIV;
          OP_ADD, OP_SUB: st_nxt = ST_NORM;
          default: st_nxt = ST_DONE;
        endcase
      end
      ST_MUL:  if (cnt_r == 7'd1) st_nxt = ST_DONE;
      ST_DIV:  if (cnt_r == 7'd0) st_nxt = ST_NORM;
      ST_NORM: if (sig_r == '0 || sig_r[63]) st_nxt = ST_DONE;
      ST_DONE: if (!out_stall) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign tq_take   = (st_r == ST_IDLE) && tq_valid;
  assign out_valid = (st_r == ST_DONE);

  always_comb begin
    out_data.res_sign        = sign_r;
    out_data.res_exponent    = exp_r[ExpW-1:0];
    out_data.res_significand = sig_r;
    out_data.compare_true    = cmp_r;
    out_data.error_code      = err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: if (tq_valid) begin
        sign_r <= 1'b0; exp_r <= '0; sig_r <= '0; cmp_r <= 1'b0; err_r <= ERR_OK;
        case (t.op)
          OP_ADD, OP_SUB: begin
            if (as_sub) begin
              if (s1 != s2) begin
                sign_r <= as_sign; exp_r <= {2'b0, big_e}; sig_r <= dif;
              end
            end else if (sum[64]) begin
              sign_r <= as_sign; exp_r <= {2'b0, big_e} + 17'd1; sig_r <= sum[64:1];
            end else begin
              sign_r <= as_sign; exp_r <= {2'b0, big_e}; sig_r <= sum[63:0];
            end
          end
          OP_MUL: if (!(t.a_zero || t.b_zero)) begin
            sign_r <= t.a_sign ^ t.b_sign;
            exp_r  <= {2'b0, t.a_exp} + {2'b0, t.b_exp} - {2'b0, ExpBias};
            ma_r   <= t.a_sig;
            mb_r   <= t.b_sig;
            prod_r <= '0;
            cnt_r  <= 7'd4;
          end
          OP_DIV: begin
            if (t.a_nan || t.b_nan) begin
              exp_r <= {2'b0, ExpMax}; sig_r <= SigNan;
            end else if (t.a_inf) begin
              if (t.b_inf) err_r <= ERR_INF_INF;
              else begin
                sign_r <= t.a_sign ^ t.b_sign; exp_r <= {2'b0, ExpMax}; sig_r <= SigTop;
              end
            end else if (t.a_zero) begin
              if (t.b_zero) err_r <= ERR_ZERO_ZERO;
              else sign_r <= t.a_sign ^ t.b_sign;
            end else if (t.b_zero || t.b_sig == '0) begin
              err_r <= ERR_DIV_ZERO;
            end else if (hi0 >= t.b_sig) begin
              if ((hi0 >> 1) >= t.b_sig) err_r <= ERR_OVERFLOW;
              else begin
                sign_r <= t.a_sign ^ t.b_sign;
                exp_r  <= {2'b0, t.a_exp} - {2'b0, t.b_exp} + {2'b0, ExpBias} + 17'd1;
                rem_r  <= hi0 >> 1;
                lo_r   <= {t.a_sig[1:0], 62'b0};
                y_r    <= t.b_sig;
                cnt_r  <= 7'd64;
              end
            end else begin
              sign_r <= t.a_sign ^ t.b_sign;
              exp_r  <= {2'b0, t.a_exp} - {2'b0, t.b_exp} + {2'b0, ExpBias};
              rem_r  <= hi0;
              lo_r   <= {t.a_sig[0], 63'b0};
              y_r    <= t.b_sig;
              cnt_r  <= 7'd64;
            end
          end
          OP_EQ: cmp_r <= eq_r1;
          OP_GT: cmp_r <= gt_r1;
          OP_LT: cmp_r <= lt_r1;
          default: ;
        endcase
      end
      ST_MUL: begin
        prod_r <= prod_sum;
        cnt_r  <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          if (prod_sum[127]) begin
            sig_r <= prod_sum[127:64];
            exp_r <= exp_r + 17'd1;
          end else begin
            sig_r <= prod_sum[126:63];
          end
        end
      end
      ST_DIV: begin
        if (cnt_r != 7'd0) begin
          rem_r <= dv_ge ? 64'(dv_sh - {1'b0, y_r}) : dv_sh[63:0];
          lo_r  <= lo_r << 1;
          sig_r <= {sig_r[62:0], dv_ge};
          cnt_r <= cnt_r - 7'd1;
        end
      end
      ST_NORM: if (!(sig_r == '0 || sig_r[63])) begin
        sig_r <= sig_r << 1;
        exp_r <= exp_r - 17'd1;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && out_stall) |=> (st_r == ST_DONE)) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    tq_take |-> (st_r == ST_IDLE)) else $error("take while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> (cnt_r <= 7'd64)) else $error("divide count out of range");

endmodule

>>> rtl/extended_float_arith_unit_core.sv
// Top level of the extended float arithmetic unit: front classifier, task queue
// and back-end executor. Depends on xfau_pkg, xfau_front, xfau_back.
//
//  channel | ports                     | beat
//  input   | in_valid/in_stall/in_data | one operation with two operands
//  output  | out_valid/out_stall/out_data | one result
//
// Compare, unused code, zero mul, div special cases and errors: straight from idle to done.
// Add, sub: computed on accept, then normalized by one-bit left shifts (up to 63).
// Mul: four 32x32 passes, no normalize.
// Div: bit-serial, one quotient bit per cycle, then normalized by one-bit left shifts (up to 63).
// Reset clears the queue and the back-end state; the queue keeps accepting until full
// while the back end works or a result is stalled.
module extended_float_arith_unit_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  xfau_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output xfau_pkg::out_item_t out_data
);
  import xfau_pkg::*;

  logic  tq_valid, tq_take;
  task_t tq_data;

  xfau_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .tq_valid, .tq_take, .tq_data
  );

  xfau_back u_back (
    .clk, .rst_n, .tq_valid, .tq_take, .tq_data,
    .out_valid, .out_stall, .out_data
  );

endmodule
